// ===== hdl/lrcd_pkg.sv =====
// shared types, widths and register codes of the lidar region collision detector
package lrcd_pkg;

    // field widths
    localparam int ANGLE_W    = 16;
    localparam int RANGE_W    = 16;
    localparam int ANG_CFG_W  = 15;
    localparam int CNT_W      = 13;
    localparam int SLIM_W     = 14;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // counter saturation ceiling that the count field can still carry
    localparam int CNT_CEIL        = 8191;
    localparam int MAX_SAMPLES_DEF = 4096;

    // register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_RANGE_LOW        = 3'd0,
        REG_RANGE_HIGH       = 3'd1,
        REG_COLLISION_RANGE  = 3'd2,
        REG_FRONT_HALF_ANGLE = 3'd3,
        REG_SIDE_ANGLE_LOW   = 3'd4,
        REG_SIDE_ANGLE_HIGH  = 3'd5,
        REG_FRONT_HIT_LIMIT  = 3'd6,
        REG_SIDE_HIT_LIMIT   = 3'd7
    } t_reg_idx;

    // register reset values
    localparam logic [RANGE_W-1:0]   RST_RANGE_LOW        = 16'd0;
    localparam logic [RANGE_W-1:0]   RST_RANGE_HIGH       = 16'd65535;
    localparam logic [ANG_CFG_W-1:0] RST_COLLISION_RANGE  = 15'd500;
    localparam logic [ANG_CFG_W-1:0] RST_FRONT_HALF_ANGLE = 15'd2144;
    localparam logic [ANG_CFG_W-1:0] RST_SIDE_ANGLE_LOW   = 15'd6434;
    localparam logic [ANG_CFG_W-1:0] RST_SIDE_ANGLE_HIGH  = 15'd19302;
    localparam logic [CNT_W-1:0]     RST_FRONT_HIT_LIMIT  = 13'd0;
    localparam logic [SLIM_W-1:0]    SIDE_LIMIT_FRONT_ONLY = 14'h3FFF;

    // configuration as seen by the datapath
    typedef struct packed {
        logic [RANGE_W-1:0]       range_low;
        logic [RANGE_W-1:0]       range_high;
        logic [ANG_CFG_W-1:0]     collision_range;
        logic [ANG_CFG_W-1:0]     front_half_angle;
        logic [ANG_CFG_W-1:0]     side_angle_low;
        logic [ANG_CFG_W-1:0]     side_angle_high;
        logic [CNT_W-1:0]         front_hit_limit;
        logic signed [SLIM_W-1:0] side_hit_limit;
    } t_cfg;

    // region hits of one sample
    typedef struct packed {
        logic left;
        logic right;
        logic front;
    } t_hits;

endpackage

// ===== hdl/lrcd_if.sv =====
// sample and scan result channel interfaces

interface lrcd_in_if import lrcd_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [ANGLE_W-1:0] angle;
    logic [RANGE_W-1:0]        range_mm;
    logic                      last;

    modport source (output valid, output angle, output range_mm, output last, input ready);
    modport sink   (input valid, input angle, input range_mm, input last, output ready);
endinterface

interface lrcd_out_if import lrcd_pkg::*; ();
    logic             valid;
    logic             ready;
    logic             collision;
    logic [CNT_W-1:0] left_count;
    logic [CNT_W-1:0] right_count;
    logic [CNT_W-1:0] front_count;

    modport source (output valid, output collision, output left_count, output right_count,
                    output front_count, input ready);
    modport sink   (input valid, input collision, input left_count, input right_count,
                    input front_count, output ready);
endinterface

// ===== hdl/lidar_region_collision_detector_top.sv =====
// lidar region collision detector top level
//
//   channel   dir  payload                                         beat taken when
//   i_in      in   angle, range_mm, last                           valid && ready
//   o_out     out  collision, left/right/front_count               valid && ready
//   i_cfg_*   in   index, data                                     i_cfg_wr_en
//
// one beat per cycle sustained while no last sample is held back; a sample passes through the input register
// and a last sample's scan result is registered from there into the output register
// a non-last sample never waits in the input register; a last sample waits there,
// holding off further beats, only while the previous scan result is still held on o_out
// synchronous active-low reset clears counters, valids and configuration registers to defaults
module lidar_region_collision_detector_top import lrcd_pkg::*; #(
    parameter int MAX_SAMPLES = MAX_SAMPLES_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    lrcd_in_if.sink               i_in,
    lrcd_out_if.source            o_out
);

    localparam int               CAP_INT = (MAX_SAMPLES < CNT_CEIL) ? MAX_SAMPLES : CNT_CEIL;
    localparam logic [CNT_W-1:0] HIT_CAP = CNT_W'(CAP_INT);

    t_cfg r_cfg;

    logic                      r_s1_valid;
    logic signed [ANGLE_W-1:0] r_s1_angle;
    logic [RANGE_W-1:0]        r_s1_range;
    logic                      r_s1_last;

    logic [CNT_W-1:0] r_left;
    logic [CNT_W-1:0] r_right;
    logic [CNT_W-1:0] r_front;
    logic [CNT_W-1:0] n_left;
    logic [CNT_W-1:0] n_right;
    logic [CNT_W-1:0] n_front;

    logic             r_out_valid;
    logic             r_out_coll;
    logic [CNT_W-1:0] r_out_left;
    logic [CNT_W-1:0] r_out_right;
    logic [CNT_W-1:0] r_out_front;
    logic             n_coll;

    t_hits hits;
    logic  s1_adv;
    logic  in_beat;
    logic  side_ok;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.range_low        <= RST_RANGE_LOW;
            r_cfg.range_high       <= RST_RANGE_HIGH;
            r_cfg.collision_range  <= RST_COLLISION_RANGE;
            r_cfg.front_half_angle <= RST_FRONT_HALF_ANGLE;
            r_cfg.side_angle_low   <= RST_SIDE_ANGLE_LOW;
            r_cfg.side_angle_high  <= RST_SIDE_ANGLE_HIGH;
            r_cfg.front_hit_limit  <= RST_FRONT_HIT_LIMIT;
            r_cfg.side_hit_limit   <= SIDE_LIMIT_FRONT_ONLY;
        end else if (i_cfg_wr_en) begin
            case (t_reg_idx'(i_cfg_index))
                REG_RANGE_LOW:        r_cfg.range_low        <= i_cfg_data;
                REG_RANGE_HIGH:       r_cfg.range_high       <= i_cfg_data;
                REG_COLLISION_RANGE:  r_cfg.collision_range  <= i_cfg_data[ANG_CFG_W-1:0];
                REG_FRONT_HALF_ANGLE: r_cfg.front_half_angle <= i_cfg_data[ANG_CFG_W-1:0];
                REG_SIDE_ANGLE_LOW:   r_cfg.side_angle_low   <= i_cfg_data[ANG_CFG_W-1:0];
                REG_SIDE_ANGLE_HIGH:  r_cfg.side_angle_high  <= i_cfg_data[ANG_CFG_W-1:0];
                REG_FRONT_HIT_LIMIT:  r_cfg.front_hit_limit  <= i_cfg_data[CNT_W-1:0];
                REG_SIDE_HIT_LIMIT:   r_cfg.side_hit_limit   <= i_cfg_data[SLIM_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // handshake: a last sample must not overwrite an untaken result
    assign s1_adv     = r_s1_valid && !(r_s1_last && r_out_valid && !o_out.ready);
    assign i_in.ready = !r_s1_valid || s1_adv;
    assign in_beat    = i_in.valid && i_in.ready;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_beat) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_beat) begin
            r_s1_angle <= i_in.angle;
            r_s1_range <= i_in.range_mm;
            r_s1_last  <= i_in.last;
        end
    end

    lrcd_classify u_classify (
        .i_cfg   (r_cfg),
        .i_angle (r_s1_angle),
        .i_range (r_s1_range),
        .o_hits  (hits)
    );

    // saturating counts including the current sample
    always_comb begin
        n_left  = r_left;
        n_right = r_right;
        n_front = r_front;
        if (hits.left && (r_left < HIT_CAP)) begin
            n_left = r_left + CNT_W'(1);
        end
        if (hits.right && (r_right < HIT_CAP)) begin
            n_right = r_right + CNT_W'(1);
        end
        if (hits.front && (r_front < HIT_CAP)) begin
            n_front = r_front + CNT_W'(1);
        end
    end

    // collision decision, side limits skipped in front-only mode
    assign side_ok = (r_cfg.side_hit_limit == SIDE_LIMIT_FRONT_ONLY) ||
                     (($signed({1'b0, n_left}) > r_cfg.side_hit_limit) &&
                      ($signed({1'b0, n_right}) > r_cfg.side_hit_limit));
    assign n_coll  = (n_front > r_cfg.front_hit_limit) && side_ok;

    // hit counters, cleared after the last sample of a scan
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left  <= '0;
            r_right <= '0;
            r_front <= '0;
        end else if (s1_adv) begin
            if (r_s1_last) begin
                r_left  <= '0;
                r_right <= '0;
                r_front <= '0;
            end else begin
                r_left  <= n_left;
                r_right <= n_right;
                r_front <= n_front;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv && r_s1_last) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv && r_s1_last) begin
            r_out_coll  <= n_coll;
            r_out_left  <= n_left;
            r_out_right <= n_right;
            r_out_front <= n_front;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.collision   = r_out_coll;
    assign o_out.left_count  = r_out_left;
    assign o_out.right_count = r_out_right;
    assign o_out.front_count = r_out_front;

endmodule

// ===== hdl/lrcd_classify.sv =====
// region classification of one lidar sample against the configured bands
module lrcd_classify import lrcd_pkg::*; (
    input  t_cfg                      i_cfg,
    input  logic signed [ANGLE_W-1:0] i_angle,
    input  logic [RANGE_W-1:0]        i_range,
    output t_hits                     o_hits
);

    logic [ANGLE_W-1:0] abs_ang;
    logic               range_ok;
    logic               side_band;
    logic               side_near;
    logic               front_band;
    logic               front_near;
    logic               positive;

    // absolute bearing, most negative angle maps to 32768
    assign abs_ang = i_angle[ANGLE_W-1] ? (~ANGLE_W'(i_angle) + ANGLE_W'(1))
                                        : ANGLE_W'(i_angle);

    // validity window on range, both ends exclusive
    assign range_ok = (i_range < i_cfg.range_high) && (i_range > i_cfg.range_low);

    // side bands use twice the collision distance
    assign side_band = (abs_ang > {1'b0, i_cfg.side_angle_low}) &&
                       (abs_ang < {1'b0, i_cfg.side_angle_high});
    assign side_near = i_range < {i_cfg.collision_range, 1'b0};

    // front sector
    assign front_band = abs_ang < {1'b0, i_cfg.front_half_angle};
    assign front_near = i_range < {1'b0, i_cfg.collision_range};

    assign positive = !i_angle[ANGLE_W-1] && (i_angle != '0);

    assign o_hits.left  = range_ok && side_band && side_near && positive;
    assign o_hits.right = range_ok && side_band && side_near && !positive;
    assign o_hits.front = range_ok && front_band && front_near;

endmodule

// ===== hdl/lrcd_checker.sv =====
// port-level checks of the lidar region collision detector, bound to the top level
module lrcd_checker import lrcd_pkg::*; #(
    parameter int MAX_SAMPLES = MAX_SAMPLES_DEF
) (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_out_valid,
    input logic             i_out_ready,
    input logic             i_out_collision,
    input logic [CNT_W-1:0] i_out_left,
    input logic [CNT_W-1:0] i_out_right,
    input logic [CNT_W-1:0] i_out_front
);

    localparam int               CAP_INT = (MAX_SAMPLES < CNT_CEIL) ? MAX_SAMPLES : CNT_CEIL;
    localparam logic [CNT_W-1:0] HIT_CAP = CNT_W'(CAP_INT);

    // a result beat never appears straight after reset
    a_reset_idle: assert property (@(posedge i_clk) !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    // a stalled result keeps its payload
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_collision) &&
        $stable(i_out_left) && $stable(i_out_right) && $stable(i_out_front))
        else $error("result changed while stalled");

    // counts stop at the saturation cap
    a_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_out_left <= HIT_CAP) && (i_out_right <= HIT_CAP) &&
        (i_out_front <= HIT_CAP))
        else $error("hit count beyond cap");

    // a collision always needs at least one front hit
    a_coll_front: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_collision |-> i_out_front != '0)
        else $error("collision without front hits");

endmodule

bind lidar_region_collision_detector_top lrcd_checker #(
    .MAX_SAMPLES (MAX_SAMPLES)
) u_lrcd_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_out_valid     (o_out.valid),
    .i_out_ready     (o_out.ready),
    .i_out_collision (o_out.collision),
    .i_out_left      (o_out.left_count),
    .i_out_right     (o_out.right_count),
    .i_out_front     (o_out.front_count)
);

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// self-checking testbench of the lidar region collision detector: predicted scan results vs o_out
module tb;
    import lrcd_pkg::*;

    localparam int HIT_CAP       = (MAX_SAMPLES_DEF < CNT_CEIL) ? MAX_SAMPLES_DEF : CNT_CEIL;
    localparam int SETTLE_CYCLES = 6;
    localparam int HOLD_CYCLES   = 300;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_SAMPLES = 120;
    localparam int LONG_SCAN     = 200;

    typedef struct {
        logic signed [ANGLE_W-1:0] angle;
        logic [RANGE_W-1:0]        range_mm;
        logic                      last;
    } t_sample;

    typedef struct {
        logic             collision;
        logic [CNT_W-1:0] left_count;
        logic [CNT_W-1:0] right_count;
        logic [CNT_W-1:0] front_count;
    } t_scan;

    // clock, reset and configuration port
    logic                  i_clk   = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    lrcd_in_if  in_ch ();
    lrcd_out_if out_ch ();

    // predictor state: settings in force and running hit counts
    t_cfg             model_cfg;
    logic [CNT_W-1:0] left_hits  = '0;
    logic [CNT_W-1:0] right_hits = '0;
    logic [CNT_W-1:0] front_hits = '0;

    t_sample sample_q[$];
    t_sample sample_now;
    t_scan   scans_due[$];

    int samples_queued = 0;
    int samples_taken  = 0;
    int tx_gap_left    = 0;
    int rx_stall_left  = 0;
    int rx_hold_left   = 0;
    int failures       = 0;
    int cycle_count    = 0;
    bit tx_idle_on     = 1'b0;
    bit rx_idle_on     = 1'b0;
    bit hold_go        = 1'b0;
    bit hold_seen      = 1'b0;

    lidar_region_collision_detector_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (cfg_wr_en),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_in        (in_ch),
        .o_out       (out_ch)
    );

    // 4 ns clock
    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    function automatic logic [CNT_W-1:0] saturating_inc(input logic [CNT_W-1:0] c);
        return (int'(c) < HIT_CAP) ? c + CNT_W'(1) : CNT_W'(HIT_CAP);
    endfunction

    // region classification of one sample, scan result on the last one
    function automatic void predict_sample(input t_sample s);
        int    ang_v;
        int    mag;
        int    rng_v;
        int    lim;
        t_scan res;
        ang_v = int'(s.angle);
        mag   = (ang_v < 0) ? -ang_v : ang_v;
        rng_v = int'(s.range_mm);
        if (rng_v > int'(model_cfg.range_low) && rng_v < int'(model_cfg.range_high)) begin
            if (mag > int'(model_cfg.side_angle_low) && mag < int'(model_cfg.side_angle_high) &&
                rng_v < 2 * int'(model_cfg.collision_range)) begin
                if (ang_v > 0) left_hits = saturating_inc(left_hits);
                else right_hits = saturating_inc(right_hits);
            end
            if (mag < int'(model_cfg.front_half_angle) &&
                rng_v < int'(model_cfg.collision_range))
                front_hits = saturating_inc(front_hits);
        end
        if (s.last) begin
            lim = int'(model_cfg.side_hit_limit);
            res.collision = front_hits > model_cfg.front_hit_limit;
            // front-only mode ignores the side counts
            if (lim != -1)
                res.collision = res.collision && (int'(left_hits) > lim) &&
                                (int'(right_hits) > lim);
            res.left_count  = left_hits;
            res.right_count = right_hits;
            res.front_count = front_hits;
            scans_due.insert(scans_due.size(), res);
            left_hits  = '0;
            right_hits = '0;
            front_hits = '0;
        end
    endfunction

    function automatic void check_field(input string what, input int want, input int got);
        if (want != got) begin
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
            failures++;
        end
    endfunction

    // sample driver: one beat from the pending queue, random gap after each when idling is on
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
            tx_gap_left = 0;
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                predict_sample(sample_now);
                samples_taken++;
            end
            if (!in_ch.valid || in_ch.ready) begin
                if (tx_gap_left > 0) begin
                    tx_gap_left--;
                    in_ch.valid <= 1'b0;
                end else if (sample_q.size() > 0) begin
                    sample_now = sample_q.pop_front();
                    in_ch.valid    <= 1'b1;
                    in_ch.angle    <= sample_now.angle;
                    in_ch.range_mm <= sample_now.range_mm;
                    in_ch.last     <= sample_now.last;
                    tx_gap_left = tx_idle_on ? $urandom_range(0, 14) : 0;
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // result monitor: check each beat, then stall or hold off ready
    always @(posedge i_clk) begin
        t_scan want;
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
            rx_stall_left = 0;
            rx_hold_left  = 0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                if (scans_due.size() == 0) begin
                    $display("%0t ns: unexpected scan result, expected none, actual %0d/%0d/%0d/%0d",
                             $time, out_ch.collision, out_ch.left_count,
                             out_ch.right_count, out_ch.front_count);
                    failures++;
                end else begin
                    want = scans_due.pop_front();
                    check_field("collision", int'(want.collision), int'(out_ch.collision));
                    check_field("left_count", int'(want.left_count), int'(out_ch.left_count));
                    check_field("right_count", int'(want.right_count),
                                int'(out_ch.right_count));
                    check_field("front_count", int'(want.front_count),
                                int'(out_ch.front_count));
                end
                rx_stall_left = rx_idle_on ? $urandom_range(0, 14) : 0;
            end
            if (hold_go != hold_seen) begin
                hold_seen    = hold_go;
                rx_hold_left = HOLD_CYCLES;
            end
            if (rx_hold_left > 0) begin
                rx_hold_left--;
                out_ch.ready <= 1'b0;
            end else if (rx_stall_left > 0) begin
                rx_stall_left--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL lidar_region_collision_detector_top");
            $finish;
        end
    end

    task automatic queue_sample(input int ang, input int rng, input bit lst);
        t_sample s;
        s.angle    = ANGLE_W'(ang);
        s.range_mm = RANGE_W'(rng);
        s.last     = lst;
        sample_q.insert(sample_q.size(), s);
        samples_queued++;
    endtask

    // all registers written back to back, then the predictor follows
    task automatic write_cfg(input t_cfg c);
        logic [CFG_DATA_W-1:0] val;
        t_reg_idx              idx;
        for (int k = 0; k <= int'(REG_SIDE_HIT_LIMIT); k++) begin
            idx = t_reg_idx'(k);
            case (idx)
                REG_RANGE_LOW:        val = c.range_low;
                REG_RANGE_HIGH:       val = c.range_high;
                REG_COLLISION_RANGE:  val = CFG_DATA_W'(c.collision_range);
                REG_FRONT_HALF_ANGLE: val = CFG_DATA_W'(c.front_half_angle);
                REG_SIDE_ANGLE_LOW:   val = CFG_DATA_W'(c.side_angle_low);
                REG_SIDE_ANGLE_HIGH:  val = CFG_DATA_W'(c.side_angle_high);
                REG_FRONT_HIT_LIMIT:  val = CFG_DATA_W'(c.front_hit_limit);
                REG_SIDE_HIT_LIMIT:   val = CFG_DATA_W'(c.side_hit_limit);
                default:              val = '0;
            endcase
            @(posedge i_clk);
            cfg_wr_en <= 1'b1;
            cfg_index <= idx;
            cfg_data  <= val;
        end
        @(posedge i_clk);
        cfg_wr_en <= 1'b0;
        model_cfg = c;
    endtask

    // wait until every sample is taken and every scan result is back
    task automatic wait_drained();
        while (samples_taken != samples_queued || scans_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // angles clustered on the region bounds of the current settings
    function automatic int pick_angle();
        int mag;
        case ($urandom_range(0, 5))
            0: mag = int'(model_cfg.front_half_angle);
            1: mag = int'(model_cfg.side_angle_low);
            2: mag = int'(model_cfg.side_angle_high);
            3: mag = $urandom_range(0, 1) ? 32768 : 0;
            4: mag = int'($urandom_range(0, 32768));
            default: return int'($urandom_range(0, 65535)) - 32768;
        endcase
        mag += int'($urandom_range(0, 4)) - 2;
        if (mag < 0) mag = 0;
        if (mag > 32768) mag = 32768;
        if ($urandom_range(0, 1)) return -mag;
        return (mag > 32767) ? 32767 : mag;
    endfunction

    // ranges clustered on the range limits and collision distances
    function automatic int pick_range();
        int v;
        case ($urandom_range(0, 6))
            0: v = int'(model_cfg.range_low);
            1: v = int'(model_cfg.range_high);
            2: v = int'(model_cfg.collision_range);
            3: v = 2 * int'(model_cfg.collision_range);
            4: v = int'($urandom_range(0, 2 * int'(model_cfg.collision_range) + 4));
            default: return int'($urandom_range(0, 65535));
        endcase
        v += int'($urandom_range(0, 4)) - 2;
        return (v < 0) ? 0 : ((v > 65535) ? 65535 : v);
    endfunction

    task automatic random_scans(input int n_samples, input int max_scan);
        int left_in_scan;
        left_in_scan = int'($urandom_range(1, max_scan));
        for (int k = 0; k < n_samples; k++) begin
            left_in_scan--;
            queue_sample(pick_angle(), pick_range(), left_in_scan == 0 || k == n_samples - 1);
            if (left_in_scan == 0) left_in_scan = int'($urandom_range(1, max_scan));
        end
    endtask

    function automatic t_cfg random_cfg();
        t_cfg c;
        c.range_low        = RANGE_W'($urandom_range(0, 3000));
        c.range_high       = RANGE_W'($urandom_range(2000, 65535));
        c.collision_range  = ANG_CFG_W'($urandom_range(50, 25000));
        c.front_half_angle = ANG_CFG_W'($urandom_range(0, 32767));
        c.side_angle_low   = ANG_CFG_W'($urandom_range(0, 20000));
        c.side_angle_high  = ANG_CFG_W'($urandom_range(int'(c.side_angle_low), 32767));
        c.front_hit_limit  = CNT_W'($urandom_range(0, 6));
        case ($urandom_range(0, 5))
            0, 1: c.side_hit_limit = SIDE_LIMIT_FRONT_ONLY;
            2: c.side_hit_limit = SLIM_W'(-2);
            3: c.side_hit_limit = {1'b1, {(SLIM_W-1){1'b0}}};
            default: c.side_hit_limit = SLIM_W'($urandom_range(0, 5));
        endcase
        return c;
    endfunction

    initial begin
        t_cfg c;
        in_ch.valid    = 1'b0;
        in_ch.angle    = '0;
        in_ch.range_mm = '0;
        in_ch.last     = 1'b0;
        out_ch.ready   = 1'b0;
        model_cfg = '{range_low: RST_RANGE_LOW, range_high: RST_RANGE_HIGH,
                      collision_range: RST_COLLISION_RANGE,
                      front_half_angle: RST_FRONT_HALF_ANGLE,
                      side_angle_low: RST_SIDE_ANGLE_LOW, side_angle_high: RST_SIDE_ANGLE_HIGH,
                      front_hit_limit: RST_FRONT_HIT_LIMIT,
                      side_hit_limit: SIDE_LIMIT_FRONT_ONLY};
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed samples on the reset settings, front-only mode
        queue_sample(0, 100, 0);
        queue_sample(-32768, 100, 0);
        queue_sample(32767, 0, 0);
        queue_sample(10000, 999, 0);
        queue_sample(-10000, 999, 0);
        queue_sample(10000, 1000, 0);
        queue_sample(6434, 10, 0);
        queue_sample(6435, 10, 0);
        queue_sample(-19301, 10, 0);
        queue_sample(19302, 10, 0);
        queue_sample(2143, 499, 1);
        queue_sample(2144, 499, 1);
        queue_sample(-2143, 499, 0);
        queue_sample(-2144, 0, 0);
        queue_sample(0, 65535, 1);
        queue_sample(0, 1, 1);
        queue_sample(1, 65534, 1);
        queue_sample(-1, 500, 1);
        queue_sample(-32768, 65535, 1);
        queue_sample(32767, 65535, 0);
        queue_sample(-1, 0, 1);
        wait_drained();

        // widest bands and limits of 4096
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        write_cfg('{range_low: 16'd0, range_high: 16'hFFFF, collision_range: 15'h7FFF,
                    front_half_angle: 15'h7FFF, side_angle_low: 15'd0,
                    side_angle_high: 15'h7FFF, front_hit_limit: 13'd4096,
                    side_hit_limit: 14'sd4096});
        random_scans(150, 20);
        wait_drained();

        // everything zero, most negative side limit
        write_cfg('{range_low: 16'd0, range_high: 16'd0, collision_range: 15'd0,
                    front_half_angle: 15'd0, side_angle_low: 15'd0, side_angle_high: 15'd0,
                    front_hit_limit: 13'd0, side_hit_limit: {1'b1, {(SLIM_W-1){1'b0}}}});
        random_scans(100, 10);
        wait_drained();

        // inverted range and side bands
        tx_idle_on = 1'b0;
        write_cfg('{range_low: 16'hFFFF, range_high: 16'd0, collision_range: 15'h7FFF,
                    front_half_angle: 15'h7FFF, side_angle_low: 15'h7FFF,
                    side_angle_high: 15'd0, front_hit_limit: 13'd0,
                    side_hit_limit: SLIM_W'(-2)});
        random_scans(100, 10);
        wait_drained();

        // random settings with every mix of idling
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            tx_idle_on = p[0];
            rx_idle_on = p[1];
            write_cfg(random_cfg());
            random_scans(PHASE_SAMPLES, int'($urandom_range(3, 40)));
            wait_drained();
        end

        // one long scan in which nearly every sample is a hit
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        write_cfg('{range_low: 16'd0, range_high: 16'hFFFF, collision_range: 15'h7FFF,
                    front_half_angle: 15'h7FFF, side_angle_low: 15'd0,
                    side_angle_high: 15'h7FFF, front_hit_limit: 13'd4095,
                    side_hit_limit: 14'sd4095});
        for (int k = 0; k < LONG_SCAN; k++)
            queue_sample(k[0] ? -int'($urandom_range(0, 32767)) : int'($urandom_range(1, 32767)),
                         int'($urandom_range(1, 32766)), k == LONG_SCAN - 1);
        queue_sample(100, 5, 0);
        queue_sample(-100, 5, 1);
        wait_drained();

        // back pressure: one-sample scans while the receiver holds off
        rx_idle_on = 1'b1;
        write_cfg(random_cfg());
        random_scans(150, 1);
        @(posedge i_clk);
        hold_go <= !hold_go;
        wait_drained();

        if (failures == 0) begin
            $display("PASS lidar_region_collision_detector_top");
        end else begin
            $display("FAIL lidar_region_collision_detector_top");
        end
        $finish;
    end

endmodule
